/* rtl/core/gasc_pkg.sv */
`default_nettype none
package gasc_pkg;
	localparam int CAPACITY = 2048;
	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int TAG_W = 21;
	localparam int SIZE_W = 8;
	localparam int CFG_W = 8;
	localparam int ENTRY_W = TAG_W + 2 * SIZE_W;
	localparam int DIV_CW = $clog2(SLOT_W + 1);
	localparam int OUT_SLOT_W = 11;
	localparam int POS_W = 20;

	localparam logic REG_CELL_SIZE = 1'b0;
	localparam logic REG_COLUMNS = 1'b1;

	localparam logic [CFG_W-1:0] CELL_SIZE_RST = 8'd32;
	localparam logic [CFG_W-1:0] COLUMNS_RST = 8'd46;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_START,
		ST_DIV,
		ST_MUL,
		ST_OUT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic [SLOT_W-1:0] quo;
		logic [CFG_W-1:0] rem;
		logic done;
	} div_res_t;
endpackage
`default_nettype wire

/* rtl/core/gasc_ram.sv */
`default_nettype none
module gasc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* rtl/core/gasc_divider.sv */
`default_nettype none
module gasc_divider (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire [gasc_pkg::SLOT_W-1:0]      dividend,
	input  wire [gasc_pkg::CFG_W-1:0]       divisor,
	output gasc_pkg::div_res_t              res
);
	logic [gasc_pkg::SLOT_W-1:0] quo_q;
	logic [gasc_pkg::CFG_W-1:0] rem_q;
	logic [gasc_pkg::CFG_W-1:0] div_q;
	logic [gasc_pkg::DIV_CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [gasc_pkg::CFG_W:0] trial;
	logic [gasc_pkg::CFG_W:0] diff;
	logic take;

	assign trial = {rem_q, quo_q[gasc_pkg::SLOT_W-1]};
	assign diff = trial - {1'b0, div_q};
	assign take = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= gasc_pkg::DIV_CW'(gasc_pkg::SLOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == gasc_pkg::DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[gasc_pkg::CFG_W-1:0] : trial[gasc_pkg::CFG_W-1:0];
			quo_q <= {quo_q[gasc_pkg::SLOT_W-2:0], take};
		end
	end

	assign res.quo = quo_q;
	assign res.rem = rem_q;
	assign res.done = done_q;

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("divider did not start");
endmodule
`default_nettype wire

/* rtl/core/glyph_atlas_slot_cache_top.sv */
// channel  | direction | handshake                    | payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata, tuser (action)
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata, tuser (flags)
// cfg      | in        | cfg_valid/cfg_ready          | cfg_index, cfg_data
// one item at a time; the tag scan reads one stored entry a cycle from the tag ram
// a miss reads all n stored entries, n = slots allocated (up to 2048)
// a hit ends the scan at its entry; a flush item goes through the output state to its clearing pass
// a flush, or a batch filling up, adds a mark-ram clearing pass over the n allocated entries
// the slot division is bit-serial; a result waiting in the output register stalls
// reset clears control state only; tag entries are valid by the allocation count
`default_nettype none
module glyph_atlas_slot_cache_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [39:0]  s_axis_tdata, // codepoint, glyph_width, glyph_height
	input  wire         s_axis_tuser, // action
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [71:0] m_axis_tdata, // slot, src_x, src_y, rect_width, rect_height
	output logic [3:0]  m_axis_tuser, // hit, needs_fill, flush_needed, cache_full
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire [7:0]   cfg_data
);
	localparam int SW = gasc_pkg::SLOT_W;
	localparam int CW = gasc_pkg::CNT_W;
	localparam int TW = gasc_pkg::TAG_W;
	localparam int ZW = gasc_pkg::SIZE_W;
	localparam int PW = gasc_pkg::POS_W;
	localparam logic [CW-1:0] CAP = CW'(gasc_pkg::CAPACITY);

	gasc_pkg::state_t state_q, state_d;
	gasc_pkg::div_res_t div_res;

	logic [7:0] cell_q, cols_q;
	logic [TW-1:0] tag_q;
	logic [ZW-1:0] gw_q, gh_q, rw_q, rh_q;
	logic hit_q, fill_q, full_q, flush_q, clear_q;
	logic [CW-1:0] scan_q, alloc_q, cnt_q, clr_q;
	logic pend_s1;
	logic [SW-1:0] addr_s1, slot_q;
	logic [PW-1:0] sx_q, sy_q;

	logic [gasc_pkg::ENTRY_W-1:0] tag_rd;
	logic tag_re, tag_we, match;
	logic mark_rd, mark_we, mark_wd, mark_re;
	logic [SW-1:0] mark_wa;
	logic [7:0] cols_eff;
	logic old_mark;
	logic [CW-1:0] cnt_next;
	logic out_free;

	assign cfg_ready = 1'b1;
	assign cols_eff = (cols_q == 8'd0) ? 8'd1 : cols_q;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign match = pend_s1 && (tag_rd[gasc_pkg::ENTRY_W-1:2*ZW] == tag_q);
	assign old_mark = fill_q ? 1'b0 : mark_rd;
	assign cnt_next = cnt_q + CW'(!old_mark);

	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		tag_re = 1'b0;
		tag_we = 1'b0;
		mark_re = 1'b0;
		mark_we = 1'b0;
		mark_wd = 1'b0;
		mark_wa = slot_q;
		case (state_q)
			gasc_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = s_axis_tuser ? gasc_pkg::ST_OUT : gasc_pkg::ST_SCAN;
				end
			end
			gasc_pkg::ST_SCAN: begin
				tag_re = (scan_q != CAP) && !match;
				if (match) begin
					state_d = gasc_pkg::ST_START;
				end else if (!tag_re && !pend_s1) begin
					if (alloc_q == CAP) begin
						state_d = gasc_pkg::ST_OUT;
					end else begin
						tag_we = 1'b1;
						state_d = gasc_pkg::ST_START;
					end
				end
			end
			gasc_pkg::ST_START: begin
				mark_re = 1'b1;
				state_d = gasc_pkg::ST_DIV;
			end
			gasc_pkg::ST_DIV: begin
				if (div_res.done) begin
					state_d = gasc_pkg::ST_MUL;
				end
			end
			gasc_pkg::ST_MUL: begin
				mark_we = !old_mark;
				mark_wd = 1'b1;
				state_d = gasc_pkg::ST_OUT;
			end
			gasc_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = clear_q ? gasc_pkg::ST_CLEAR : gasc_pkg::ST_IDLE;
				end
			end
			gasc_pkg::ST_CLEAR: begin
				mark_wa = clr_q[SW-1:0];
				if (clr_q == CAP) begin
					state_d = gasc_pkg::ST_IDLE;
				end else begin
					mark_we = 1'b1;
				end
			end
			default: state_d = gasc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gasc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= gasc_pkg::CELL_SIZE_RST;
			cols_q <= gasc_pkg::COLUMNS_RST;
			alloc_q <= '0;
			cnt_q <= '0;
			pend_s1 <= 1'b0;
			m_axis_tvalid <= 1'b0;
			clear_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == gasc_pkg::REG_CELL_SIZE) begin
					cell_q <= cfg_data;
				end else begin
					cols_q <= cfg_data;
				end
			end
			if (state_q == gasc_pkg::ST_OUT && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				gasc_pkg::ST_IDLE: begin
					pend_s1 <= 1'b0;
					clear_q <= s_axis_tvalid && s_axis_tuser;
				end
				gasc_pkg::ST_SCAN: begin
					pend_s1 <= tag_re;
					if (tag_we) begin
						alloc_q <= alloc_q + 1'b1;
					end
				end
				gasc_pkg::ST_MUL: begin
					if (cnt_next == CAP) begin
						cnt_q <= '0;
						clear_q <= 1'b1;
					end else begin
						cnt_q <= cnt_next;
					end
				end
				gasc_pkg::ST_OUT: begin
					if (out_free && clear_q) begin
						cnt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			gasc_pkg::ST_IDLE: begin
				tag_q <= s_axis_tdata[TW-1:0];
				gw_q <= s_axis_tdata[TW+ZW-1:TW];
				gh_q <= s_axis_tdata[TW+2*ZW-1:TW+ZW];
				scan_q <= CAP - alloc_q;
				hit_q <= 1'b0;
				fill_q <= 1'b0;
				full_q <= 1'b0;
				flush_q <= 1'b0;
				slot_q <= '0;
				rw_q <= '0;
				rh_q <= '0;
				sx_q <= '0;
				sy_q <= '0;
			end
			gasc_pkg::ST_SCAN: begin
				if (tag_re) begin
					scan_q <= scan_q + 1'b1;
				end
				addr_s1 <= scan_q[SW-1:0];
				if (match) begin
					hit_q <= 1'b1;
					slot_q <= addr_s1;
					rw_q <= tag_rd[2*ZW-1:ZW];
					rh_q <= tag_rd[ZW-1:0];
				end else if (!tag_re && !pend_s1) begin
					if (alloc_q == CAP) begin
						full_q <= 1'b1;
					end else begin
						fill_q <= 1'b1;
						slot_q <= SW'(CAP - 1'b1 - alloc_q);
						rw_q <= gw_q;
						rh_q <= gh_q;
					end
				end
			end
			gasc_pkg::ST_MUL: begin
				sx_q <= PW'(div_res.rem) * PW'(cell_q);
				sy_q <= PW'(div_res.quo) * PW'(cell_q);
				flush_q <= (cnt_next == CAP);
			end
			gasc_pkg::ST_OUT: begin
				clr_q <= CAP - alloc_q;
				if (out_free) begin
					m_axis_tdata <= {5'd0, rh_q, rw_q, sy_q, sx_q,
						gasc_pkg::OUT_SLOT_W'(slot_q)};
					m_axis_tuser <= {full_q, flush_q, fill_q, hit_q};
				end
			end
			gasc_pkg::ST_CLEAR: begin
				if (clr_q != CAP) begin
					clr_q <= clr_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	gasc_ram #(.WIDTH(gasc_pkg::ENTRY_W), .DEPTH(gasc_pkg::CAPACITY)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (SW'(CAP - 1'b1 - alloc_q)),
		.wdata ({tag_q, gw_q, gh_q}),
		.re    (tag_re),
		.raddr (scan_q[SW-1:0]),
		.rdata (tag_rd)
	);

	gasc_ram #(.WIDTH(1), .DEPTH(gasc_pkg::CAPACITY)) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_wa),
		.wdata (mark_wd),
		.re    (mark_re),
		.raddr (slot_q),
		.rdata (mark_rd)
	);

	gasc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == gasc_pkg::ST_START),
		.dividend (slot_q),
		.divisor  (cols_eff),
		.res      (div_res)
	);

	a_alloc_cap: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_q <= CAP) else $error("allocation count beyond capacity");
	a_cnt_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= alloc_q) else $error("batch count beyond allocated slots");
	a_hit_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("hit and fill together");
	a_full_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[3]) |-> (alloc_q == CAP))
		else $error("cache full reported with free slots");
endmodule
`default_nettype wire
